[design/tvip_pkg.sv]
// Shared constants, widths and types of the TV inpainting pixel update core.
// Depends on nothing; every other file of the core imports it.
`timescale 1ns / 1ps

package tvip_pkg;

    // Pixel and register formats
    localparam int PIXEL_FRAC_BITS = 8;
    localparam int PIX_W           = 16;
    localparam int CFG_W           = 16;
    localparam int LAM_FRAC        = 12;
    localparam int WEIGHT_FRAC     = 20;
    localparam int ROOT_EXTRA      = 13;

    // Gradient stage widths
    localparam int DIFF_W = PIX_W + 1;          // doubled centre difference
    localparam int ASQ_W  = 2 * DIFF_W;
    localparam int BSQ_W  = 2 * PIX_W;
    localparam int S_W    = ASQ_W + 2;          // sum of three squares

    // Root and reciprocal
    localparam int ROOT_W      = (S_W + 2 * ROOT_EXTRA) / 2;
    localparam int SQ_REM_W    = ROOT_W + 1;
    localparam int RECIP_SHIFT = PIXEL_FRAC_BITS + 1 + ROOT_EXTRA + WEIGHT_FRAC;
    // smallest root is 2^(ROOT_EXTRA+1), so the weight needs this many bits
    localparam int W_W         = RECIP_SHIFT - ROOT_EXTRA;
    localparam logic [ROOT_W-1:0] RECIP_INIT = ROOT_W'(1) << (RECIP_SHIFT - W_W);

    // Weighted mix and final quotient
    localparam int LAM_W   = CFG_W + WEIGHT_FRAC - LAM_FRAC;
    localparam int PROD_W  = W_W + PIX_W;
    localparam int LPROD_W = LAM_W + PIX_W;
    localparam int DEN_W   = W_W + 2;
    localparam int NUM_W   = PROD_W + 2;
    localparam int DIV_W   = NUM_W + 1;
    localparam int QUO_W   = PIX_W + 1;

    // Pipeline depths
    localparam int GRAD_STAGES  = 3;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int RECIP_STAGES = W_W;
    localparam int MIX_STAGES   = 3;
    localparam int QDIV_STAGES  = QUO_W + 1;
    localparam int LANES        = 4;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIDELITY_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRADIENT_FLOOR  = 1'b1;
    localparam logic [CFG_W-1:0]     FIDELITY_RESET      = 16'd819;
    localparam logic [CFG_W-1:0]     FLOOR_RESET         = 16'd128;

    typedef logic [PIX_W-1:0] t_pix;

    // Pixels that ride alongside the gradient and weight pipelines
    typedef struct packed {
        t_pix pix_north;
        t_pix pix_east;
        t_pix pix_west;
        t_pix pix_south;
        t_pix pix_centre;
        logic damaged;
    } t_side;

    typedef struct packed {
        t_pix pix_centre;
        logic damaged;
    } t_keep;

endpackage

[design/tvip_isqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on tvip_pkg; the radicand is scaled by 2^(2*ROOT_EXTRA) internally.
`timescale 1ns / 1ps

module tvip_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tvip_pkg::S_W-1:0]    i_rad,
    output logic [tvip_pkg::ROOT_W-1:0] o_root
);
    import tvip_pkg::*;

    logic [S_W-1:0]      r_x    [SQRT_STAGES];
    logic [SQ_REM_W-1:0] r_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]   r_root [SQRT_STAGES];
    logic [S_W-1:0]      n_x    [SQRT_STAGES];
    logic [SQ_REM_W-1:0] n_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0]   n_root [SQRT_STAGES];
    logic [S_W-1:0]      x_src    [SQRT_STAGES];
    logic [SQ_REM_W-1:0] rem_src  [SQRT_STAGES];
    logic [ROOT_W-1:0]   root_src [SQRT_STAGES];
    logic [SQ_REM_W+1:0] sh       [SQRT_STAGES];
    logic [SQ_REM_W+1:0] trial    [SQRT_STAGES];

    always_comb begin
        x_src[0]    = i_rad;
        rem_src[0]  = '0;
        root_src[0] = '0;
        for (int k = 1; k < SQRT_STAGES; k++) begin
            x_src[k]    = r_x[k-1];
            rem_src[k]  = r_rem[k-1];
            root_src[k] = r_root[k-1];
        end
        for (int k = 0; k < SQRT_STAGES; k++) begin
            // radicand bits run out after S_W/2 steps; zeros shift in behind them
            sh[k]    = {rem_src[k], x_src[k][S_W-1 -: 2]};
            trial[k] = {1'b0, root_src[k], 2'b01};
            n_x[k]   = {x_src[k][S_W-3:0], 2'b00};
            if (sh[k] >= trial[k]) begin
                n_rem[k]  = SQ_REM_W'(sh[k] - trial[k]);
                n_root[k] = {root_src[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = SQ_REM_W'(sh[k]);
                n_root[k] = {root_src[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STAGES; k++) begin
                r_x[k]    <= n_x[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];

endmodule

[design/tvip_recip.sv]
// Pipelined reciprocal 2^RECIP_SHIFT / root, one quotient bit per stage.
// Depends on tvip_pkg; the dividend has only one set bit, so zeros shift in.
`timescale 1ns / 1ps

module tvip_recip (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [tvip_pkg::ROOT_W-1:0] i_root,
    output logic [tvip_pkg::W_W-1:0]    o_weight
);
    import tvip_pkg::*;

    logic [ROOT_W-1:0] r_d   [RECIP_STAGES];
    logic [ROOT_W-1:0] r_rem [RECIP_STAGES];
    logic [W_W-1:0]    r_q   [RECIP_STAGES];
    logic [ROOT_W-1:0] n_rem [RECIP_STAGES];
    logic [W_W-1:0]    n_q   [RECIP_STAGES];
    logic [ROOT_W-1:0] d_src   [RECIP_STAGES];
    logic [ROOT_W-1:0] rem_src [RECIP_STAGES];
    logic [W_W-1:0]    q_src   [RECIP_STAGES];
    logic [ROOT_W:0]   sh      [RECIP_STAGES];

    always_comb begin
        d_src[0]   = i_root;
        rem_src[0] = RECIP_INIT;
        q_src[0]   = '0;
        for (int k = 1; k < RECIP_STAGES; k++) begin
            d_src[k]   = r_d[k-1];
            rem_src[k] = r_rem[k-1];
            q_src[k]   = r_q[k-1];
        end
        for (int k = 0; k < RECIP_STAGES; k++) begin
            sh[k] = {rem_src[k], 1'b0};
            if (sh[k] >= {1'b0, d_src[k]}) begin
                n_rem[k] = ROOT_W'(sh[k] - {1'b0, d_src[k]});
                n_q[k]   = {q_src[k][W_W-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[k][ROOT_W-1:0];
                n_q[k]   = {q_src[k][W_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RECIP_STAGES; k++) begin
                r_d[k]   <= d_src[k];
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_weight = r_q[RECIP_STAGES-1];

endmodule

[design/tvip_mix.sv]
// Weighted mix: five products, then numerator and denominator sums over two stages.
// Depends on tvip_pkg.
`timescale 1ns / 1ps

module tvip_mix (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [tvip_pkg::LANES-1:0][tvip_pkg::W_W-1:0]   i_weight,
    input  logic [tvip_pkg::LANES-1:0][tvip_pkg::PIX_W-1:0] i_pix,
    input  logic [tvip_pkg::PIX_W-1:0]                   i_centre,
    input  logic [tvip_pkg::CFG_W-1:0]                   i_lambda,
    output logic [tvip_pkg::NUM_W-1:0]                   o_num,
    output logic [tvip_pkg::DEN_W-1:0]                   o_den
);
    import tvip_pkg::*;

    logic [LAM_W-1:0]   lam;
    logic [PROD_W-1:0]  r_p [LANES];
    logic [LPROD_W-1:0] r_pl;
    logic [W_W:0]       r_da;
    logic [W_W:0]       r_db;
    logic [LAM_W-1:0]   r_lam;
    logic [PROD_W:0]    r_na;
    logic [PROD_W:0]    r_nb;
    logic [LPROD_W-1:0] r_pl2;
    logic [DEN_W-1:0]   r_dsum;
    logic [LAM_W-1:0]   r_lam2;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;

    // lambda from Q4.12 to the weight scale
    assign lam = {i_lambda, {(WEIGHT_FRAC - LAM_FRAC){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < LANES; k++) begin
                r_p[k] <= PROD_W'(i_weight[k]) * PROD_W'(i_pix[k]);
            end
            r_pl  <= LPROD_W'(lam) * LPROD_W'(i_centre);
            r_da  <= (W_W+1)'(i_weight[0]) + (W_W+1)'(i_weight[1]);
            r_db  <= (W_W+1)'(i_weight[2]) + (W_W+1)'(i_weight[3]);
            r_lam <= lam;

            r_na   <= (PROD_W+1)'(r_p[0]) + (PROD_W+1)'(r_p[1]);
            r_nb   <= (PROD_W+1)'(r_p[2]) + (PROD_W+1)'(r_p[3]);
            r_pl2  <= r_pl;
            r_dsum <= DEN_W'(r_da) + DEN_W'(r_db);
            r_lam2 <= r_lam;

            r_num <= NUM_W'(r_na) + NUM_W'(r_nb) + NUM_W'(r_pl2);
            r_den <= r_dsum + DEN_W'(r_lam2);
        end
    end

    assign o_num = r_num;
    assign o_den = r_den;

endmodule

[design/tvip_qdiv.sv]
// Pipelined rounded quotient (num + den/2) / den, one bit per stage after a setup stage.
// Depends on tvip_pkg; the quotient is known to fit QUO_W bits.
`timescale 1ns / 1ps

module tvip_qdiv (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [tvip_pkg::NUM_W-1:0] i_num,
    input  logic [tvip_pkg::DEN_W-1:0] i_den,
    output logic [tvip_pkg::QUO_W-1:0] o_quo
);
    import tvip_pkg::*;

    logic [DIV_W-1:0] n_sum;
    logic [DEN_W-1:0] r_rem0;
    logic [QUO_W-1:0] r_low0;
    logic [DEN_W-1:0] r_den0;
    logic [DEN_W-1:0] r_d   [QUO_W];
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_q   [QUO_W];
    logic [DEN_W-1:0] n_rem [QUO_W];
    logic [QUO_W-1:0] n_q   [QUO_W];
    logic [QUO_W-1:0] n_low [QUO_W];
    logic [DEN_W-1:0] d_src   [QUO_W];
    logic [DEN_W-1:0] rem_src [QUO_W];
    logic [QUO_W-1:0] low_src [QUO_W];
    logic [QUO_W-1:0] q_src   [QUO_W];
    logic [DEN_W:0]   sh      [QUO_W];

    // round half up by adding half the divisor
    assign n_sum = DIV_W'(i_num) + DIV_W'(i_den >> 1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= n_sum[DIV_W-1 -: DEN_W];
            r_low0 <= n_sum[QUO_W-1:0];
            r_den0 <= i_den;
        end
    end

    always_comb begin
        d_src[0]   = r_den0;
        rem_src[0] = r_rem0;
        low_src[0] = r_low0;
        q_src[0]   = '0;
        for (int k = 1; k < QUO_W; k++) begin
            d_src[k]   = r_d[k-1];
            rem_src[k] = r_rem[k-1];
            low_src[k] = r_low[k-1];
            q_src[k]   = r_q[k-1];
        end
        for (int k = 0; k < QUO_W; k++) begin
            sh[k]    = {rem_src[k], low_src[k][QUO_W-1]};
            n_low[k] = {low_src[k][QUO_W-2:0], 1'b0};
            if (sh[k] >= {1'b0, d_src[k]}) begin
                n_rem[k] = DEN_W'(sh[k] - {1'b0, d_src[k]});
                n_q[k]   = {q_src[k][QUO_W-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[k][DEN_W-1:0];
                n_q[k]   = {q_src[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_d[k]   <= d_src[k];
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_low[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_quo = r_q[QUO_W-1];

endmodule

[design/tv_inpaint_pixel_update_core.sv]
// Top level of the TV inpainting pixel update core: gradient stages, lanes, control.
// Depends on tvip_pkg, tvip_isqrt, tvip_recip, tvip_mix and tvip_qdiv.
`timescale 1ns / 1ps

// One total-variation inpainting update per pixel. Each input transfer carries a
// 3x3 neighbourhood (unsigned Q8.8) and a damaged flag; each yields exactly one
// output transfer with the new centre pixel, in order. Undamaged pixels come out
// unchanged. The core takes one pixel per clock while the output is not stalled
// and holds up to 85 items in flight: 3 gradient stages, a 31-stage square root, a
// 29-stage reciprocal (four lanes each, one per direction), 3 mix stages, an
// 18-stage rounding divider and the output register. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// s_axis_tready drops only while a finished result waits downstream.
// Write fidelity_weight (index 0, Q4.12) and gradient_floor (index 1, Q8.8)
// only while no items are in flight; a floor of zero acts as one.

module tv_inpaint_pixel_update_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // fidelity_weight, gradient_floor: one write per enabled clock
    input  logic                           i_cfg_we,
    input  logic [tvip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tvip_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // from bit 0: pix_centre, pix_north, pix_south, pix_east, pix_west,
    // pix_northeast, pix_northwest, pix_southeast, pix_southwest (16 bits each)
    input  logic [143:0]                   i_s_axis_tdata,
    // bit 0: damaged
    input  logic [0:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // bits 15:0: pix_new
    output logic [15:0]                    o_m_axis_tdata
);
    import tvip_pkg::*;

    localparam int SBA_DEPTH  = GRAD_STAGES + SQRT_STAGES + RECIP_STAGES;
    localparam int SBB_DEPTH  = MIX_STAGES + QDIV_STAGES;
    localparam int PIPE_DEPTH = SBA_DEPTH + SBB_DEPTH;

    function automatic t_pix abs_diff(input t_pix a, input t_pix b);
        return (a >= b) ? t_pix'(a - b) : t_pix'(b - a);
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] r_fidelity_weight;
    logic [CFG_W-1:0] r_gradient_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fidelity_weight <= FIDELITY_RESET;
            r_gradient_floor  <= FLOOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIDELITY_WEIGHT: begin
                    r_fidelity_weight <= i_cfg_data;
                end
                CFG_GRADIENT_FLOOR: begin
                    r_gradient_floor <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Pipeline advance: move everything when the output slot frees up
    logic en;
    logic r_m_tvalid;
    logic [PIX_W-1:0] r_m_tdata;

    assign en              = !r_m_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // Unpack the neighbourhood
    t_pix  c, pn, ps, pe, pw, pne, pnw, pse, psw;
    t_side side_in;
    t_pix  nb [LANES];
    t_pix  cp [LANES];
    t_pix  cq [LANES];

    assign c   = i_s_axis_tdata[15:0];
    assign pn  = i_s_axis_tdata[31:16];
    assign ps  = i_s_axis_tdata[47:32];
    assign pe  = i_s_axis_tdata[63:48];
    assign pw  = i_s_axis_tdata[79:64];
    assign pne = i_s_axis_tdata[95:80];
    assign pnw = i_s_axis_tdata[111:96];
    assign pse = i_s_axis_tdata[127:112];
    assign psw = i_s_axis_tdata[143:128];

    // lanes: north, east, west, south; each with its two corners
    always_comb begin
        nb[0] = pn;  cp[0] = pnw; cq[0] = pne;
        nb[1] = pe;  cp[1] = pne; cq[1] = pse;
        nb[2] = pw;  cp[2] = pnw; cq[2] = psw;
        nb[3] = ps;  cp[3] = psw; cq[3] = pse;
        side_in = '{pix_north: pn, pix_east: pe, pix_west: pw, pix_south: ps,
                    pix_centre: c, damaged: i_s_axis_tuser[0]};
    end

    // Gradient stages: differences, squares, sum of squares
    logic [DIFF_W-1:0] r_a    [LANES];
    logic [PIX_W-1:0]  r_b    [LANES];
    logic [CFG_W-1:0]  r_delta;
    logic [ASQ_W-1:0]  r_asq  [LANES];
    logic [BSQ_W-1:0]  r_bsq  [LANES];
    logic [BSQ_W-1:0]  r_dsq;
    logic [S_W-1:0]    r_rad  [LANES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < LANES; k++) begin
                // doubled so that the corner difference needs no halving
                r_a[k] <= {abs_diff(c, nb[k]), 1'b0};
                r_b[k] <= abs_diff(cp[k], cq[k]);
            end
            r_delta <= (r_gradient_floor == '0) ? CFG_W'(1) : r_gradient_floor;

            for (int k = 0; k < LANES; k++) begin
                r_asq[k] <= ASQ_W'(r_a[k]) * ASQ_W'(r_a[k]);
                r_bsq[k] <= BSQ_W'(r_b[k]) * BSQ_W'(r_b[k]);
            end
            r_dsq <= BSQ_W'(r_delta) * BSQ_W'(r_delta);

            for (int k = 0; k < LANES; k++) begin
                r_rad[k] <= S_W'(r_asq[k]) + S_W'(r_bsq[k]) + S_W'({r_dsq, 2'b00});
            end
        end
    end

    // Root and weight lanes
    logic [ROOT_W-1:0]                 w_root [LANES];
    logic [LANES-1:0][W_W-1:0]         w_weight;
    logic [LANES-1:0][PIX_W-1:0]       w_pix;
    logic [NUM_W-1:0]                  w_num;
    logic [DEN_W-1:0]                  w_den;
    logic [QUO_W-1:0]                  w_quo;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        tvip_isqrt u_isqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  (r_rad[k]),
            .o_root (w_root[k])
        );

        tvip_recip u_recip (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_root   (w_root[k]),
            .o_weight (w_weight[k])
        );
    end

    // Sideband delay lines and valid bits
    t_side r_sba [SBA_DEPTH];
    t_keep r_sbb [SBB_DEPTH];
    logic [PIPE_DEPTH-1:0] r_vld;
    t_side sba_out;
    t_keep sbb_out;

    assign sba_out = r_sba[SBA_DEPTH-1];
    assign sbb_out = r_sbb[SBB_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sba[0] <= side_in;
            for (int k = 1; k < SBA_DEPTH; k++) begin
                r_sba[k] <= r_sba[k-1];
            end
            r_sbb[0] <= '{pix_centre: sba_out.pix_centre, damaged: sba_out.damaged};
            for (int k = 1; k < SBB_DEPTH; k++) begin
                r_sbb[k] <= r_sbb[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    assign w_pix = {sba_out.pix_south, sba_out.pix_west, sba_out.pix_east,
                    sba_out.pix_north};

    tvip_mix u_mix (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_weight (w_weight),
        .i_pix    (w_pix),
        .i_centre (sba_out.pix_centre),
        .i_lambda (r_fidelity_weight),
        .o_num    (w_num),
        .o_den    (w_den)
    );

    tvip_qdiv u_qdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (w_num),
        .i_den (w_den),
        .o_quo (w_quo)
    );

    // Output register: pick the update or pass the centre through, clamp to 16 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (en) begin
            r_m_tvalid <= r_vld[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (!sbb_out.damaged) begin
                r_m_tdata <= sbb_out.pix_centre;
            end else if (w_quo[QUO_W-1]) begin
                r_m_tdata <= '1;
            end else begin
                r_m_tdata <= w_quo[PIX_W-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;

    // Checks on the pipeline and the arithmetic bounds
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[GRAD_STAGES+SQRT_STAGES-1] |->
            (w_root[0][ROOT_W-1:ROOT_EXTRA+1] != '0) &&
            (w_root[1][ROOT_W-1:ROOT_EXTRA+1] != '0) &&
            (w_root[2][ROOT_W-1:ROOT_EXTRA+1] != '0) &&
            (w_root[3][ROOT_W-1:ROOT_EXTRA+1] != '0))
        else $error("gradient root below the floor term");

    a_quo_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[PIPE_DEPTH-1] |-> !w_quo[QUO_W-1])
        else $error("weighted mix exceeded the pixel range");

endmodule

[tb/tvip_checker.sv]
// Checker for the TV inpainting pixel update core: watches both stream channels,
// predicts each new pixel from its neighbourhood and compares in order. Uses tvip_pkg.
`timescale 1ns / 1ps

module tvip_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tvip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tvip_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [143:0]                   i_s_tdata,
    input  logic [0:0]                     i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [15:0]                    i_m_tdata,
    output int                             o_errors,
    output int                             o_pending,
    output int                             o_results
);
    import tvip_pkg::*;

    logic [15:0] lambda_q412;
    logic [15:0] delta_q88;
    logic [15:0] pix_new_q[$];

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] dir_weight(input logic [15:0] c, input logic [15:0] x,
                                               input logic [15:0] p, input logic [15:0] q,
                                               input logic [63:0] dl);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        a = 2 * ((c >= x) ? 64'(c - x) : 64'(x - c));
        b = (p >= q) ? 64'(p - q) : 64'(q - p);
        r = root64((a * a + b * b + 4 * dl * dl) << (2 * ROOT_EXTRA));
        if (r == 0) r = 1;
        return (64'd1 << RECIP_SHIFT) / r;
    endfunction

    function automatic logic [15:0] predict_pixel(input logic [143:0] d, input logic dmg);
        logic [15:0] px[9];
        logic [63:0] dl, wn, we, ww, ws, lm, den, num, res;
        for (int k = 0; k < 9; k++) px[k] = d[16*k +: 16];
        if (!dmg) return px[0];
        dl = (delta_q88 == 0) ? 64'd1 : 64'(delta_q88);
        // corner order: nw=6, ne=5, se=7, sw=8
        wn = dir_weight(px[0], px[1], px[6], px[5], dl);
        we = dir_weight(px[0], px[3], px[5], px[7], dl);
        ww = dir_weight(px[0], px[4], px[6], px[8], dl);
        ws = dir_weight(px[0], px[2], px[8], px[7], dl);
        lm = 64'(lambda_q412) << (WEIGHT_FRAC - LAM_FRAC);
        den = wn + we + ww + ws + lm;
        num = wn * px[1] + we * px[3] + ww * px[4] + ws * px[2] + lm * px[0];
        res = (num + den / 2) / den;
        return (res > 64'hFFFF) ? 16'hFFFF : res[15:0];
    endfunction

    assign o_pending = pix_new_q.size();

    always @(posedge i_clk) begin
        logic [15:0] want;
        if (!i_rst_n) begin
            lambda_q412 <= FIDELITY_RESET;
            delta_q88   <= FLOOR_RESET;
            o_errors    <= 0;
            o_results   <= 0;
            pix_new_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIDELITY_WEIGHT) lambda_q412 <= i_cfg_data;
                else if (i_cfg_idx == CFG_GRADIENT_FLOOR) delta_q88 <= i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                pix_new_q.push_back(predict_pixel(i_s_tdata, i_s_tuser[0]));
            if (i_m_tvalid && i_m_tready) begin
                o_results <= o_results + 1;
                if (pix_new_q.size() == 0) begin
                    $display("%0t: unexpected pix_new expected none actual %h",
                             $time, i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = pix_new_q.pop_front();
                    if (want !== i_m_tdata) begin
                        $display("%0t: pix_new mismatch expected %h actual %h",
                                 $time, want, i_m_tdata);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/testbench.sv]
// Top of the TV inpainting pixel update testbench: clock, reset, stimulus, verdict.
// Depends on tvip_pkg, tvip_checker and the core tv_inpaint_pixel_update_core.
`timescale 1ns / 1ps

module testbench;
    import tvip_pkg::*;

    localparam int LATENCY  = 85;
    localparam int WDOG_MAX = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [143:0]         s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    int                   errors;
    int                   pending;
    int                   results;
    int                   idle_pct;   // sender gap odds
    int                   stall_pct;  // receiver stall odds
    int                   hold_cycles;
    logic                 hold_req;
    logic                 hold_done;
    int                   quiet;
    int                   pixels_sent;

    always begin
        clk = 1'b0; #1;
        clk = 1'b1; #1;
    end

    tv_inpaint_pixel_update_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    tvip_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Receiver: stall at random, or hold off entirely for a long stretch.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready    <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready    <= 1'b0;
            hold_cycles <= 300;
            hold_done   <= 1'b1;
        end else if (hold_cycles > 0) begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= WDOG_MAX) begin
                $display("%0t: watchdog expired with %0d results pending", $time, pending);
                $display("tv_inpaint_pixel_update_core verification failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Drain every expected pixel, then let the pipeline settle.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // Offer one neighbourhood and hold it until the core takes it.
    task automatic send_pixel(input logic [143:0] nb, input logic dmg);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= nb;
        s_tuser  <= dmg;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pixels_sent++;
    endtask

    // Random neighbourhood: smooth patches, edges, or pure noise.
    function automatic logic [143:0] rand_hood();
        logic [143:0] nb;
        logic [15:0]  base;
        int           mode;
        mode = $urandom_range(3);
        base = 16'($urandom);
        for (int k = 0; k < 9; k++) begin
            case (mode)
                0: nb[16*k +: 16] = 16'($urandom);
                1: nb[16*k +: 16] = base + 16'($urandom_range(64)) - 16'd32;
                2: nb[16*k +: 16] = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
                default: nb[16*k +: 16] = ($urandom_range(1) != 0) ? base : ~base;
            endcase
        end
        return nb;
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < count; k++)
            send_pixel(rand_hood(), $urandom_range(99) < 80);
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [15:0] ramp;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 1'b0;
        pixels_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, flat, extremes, undamaged pass-through.
        send_pixel({9{16'h0000}}, 1'b1);
        send_pixel({9{16'hFFFF}}, 1'b1);
        send_pixel({{8{16'h0000}}, 16'hFFFF}, 1'b1);
        send_pixel({{8{16'hFFFF}}, 16'h0000}, 1'b1);
        send_pixel({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h1234,
                    16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555}, 1'b1);
        send_pixel({9{16'hA5A5}}, 1'b0);
        send_pixel({{8{16'h0000}}, 16'hFFFF}, 1'b0);
        for (int k = 0; k < 9; k++) begin
            ramp = 16'(k) * 16'h1C71;
            send_pixel({9{ramp}} ^ (144'hFFFF << (16 * k)), 1'b1);
        end
        s_tvalid <= 1'b0;
        drain();

        // Extremes of both registers: zero lambda with zero floor, then maxima.
        write_reg(CFG_FIDELITY_WEIGHT, 16'h0000);
        write_reg(CFG_GRADIENT_FLOOR, 16'h0000);
        send_pixel({{8{16'h0000}}, 16'hFFFF}, 1'b1);
        send_pixel({16'h0001, {7{16'h0000}}, 16'h0080}, 1'b1);
        random_phase(20, 0, 0);
        drain();
        write_reg(CFG_FIDELITY_WEIGHT, 16'hFFFF);
        write_reg(CFG_GRADIENT_FLOOR, 16'hFFFF);
        send_pixel({{8{16'h0000}}, 16'hFFFF}, 1'b1);
        random_phase(30, 0, 0);
        drain();

        // Reset fidelity weight with a floor of one, then random settings with sender gaps.
        write_reg(CFG_FIDELITY_WEIGHT, FIDELITY_RESET);
        write_reg(CFG_GRADIENT_FLOOR, 16'h0001);
        random_phase(80, 0, 0);
        drain();
        write_reg(CFG_FIDELITY_WEIGHT, 16'($urandom));
        write_reg(CFG_GRADIENT_FLOOR, 16'($urandom));
        random_phase(80, 45, 0);
        drain();

        // Long receiver hold-off while the sender keeps offering; more items
        // than the pipeline holds, so the input stalls.
        hold_req <= 1'b1;
        write_reg(CFG_FIDELITY_WEIGHT, 16'h1000);
        write_reg(CFG_GRADIENT_FLOOR, FLOOR_RESET);
        random_phase(100, 0, 45);
        drain();
        write_reg(CFG_FIDELITY_WEIGHT, 16'($urandom_range(4096)));
        write_reg(CFG_GRADIENT_FLOOR, 16'($urandom_range(1024)));
        random_phase(70, 11, 11);

        drain();
        $display("Covered %0d neighbourhoods (%0d results) over register extremes,",
                 pixels_sent, results);
        $display("random settings, sender gaps, receiver stalls and a long hold-off.");
        if (errors == 0) begin
            $display("tv_inpaint_pixel_update_core verification clean");
        end else begin
            $display("tv_inpaint_pixel_update_core verification failed");
        end
        $finish;
    end
endmodule

[tv_inpaint_pixel_update_core.f]
design/tvip_pkg.sv
design/tvip_isqrt.sv
design/tvip_recip.sv
design/tvip_mix.sv
design/tvip_qdiv.sv
design/tv_inpaint_pixel_update_core.sv
tb/tvip_checker.sv
tb/testbench.sv
